// ----- hdl/bdh_pkg.sv -----
`timescale 1ns / 1ps

package bdh_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int TIME_BITS_DEF   = 32;

  // Buttons visible on the result beat (fixed by the result field widths)
  localparam int OUT_BUTTONS = 4;

  localparam int NOW_W     = 32;
  localparam int RAW_W     = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WINDOW = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST        = 16'd1000;
  localparam logic [CFG_W-1:0] EDGE_WINDOW_RST = 16'd200;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_HELD     = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] edge_window_ms;
  } cfg_t;

  typedef struct packed {
    logic   pressed;
    logic   press_edge;
    logic   release_edge;
    logic   held;
    logic   recent;
    event_t ev;
  } btn_status_t;

endpackage

// ----- hdl/bdh_button.sv -----
`timescale 1ns / 1ps

// One button: debounce, press/hold tracking, event code for the current beat.
module bdh_button #(
  parameter int TIME_BITS = bdh_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 level,
  input  bdh_pkg::cfg_t        cfg,
  output bdh_pkg::btn_status_t status
);

  logic                 last_raw;
  logic [TIME_BITS-1:0] change_time;
  logic                 pressed;
  logic [TIME_BITS-1:0] press_start;
  logic                 held;

  logic                 last_raw_next;
  logic [TIME_BITS-1:0] change_time_next;
  logic                 pressed_next;
  logic [TIME_BITS-1:0] press_start_next;
  logic                 held_next;
  logic                 press_edge;
  logic                 release_edge;
  logic                 stable;
  logic                 want;
  logic                 recent;

  always_comb begin
    last_raw_next    = level;
    change_time_next = (level != last_raw) ? now : change_time;
    stable           = (now - change_time_next) > TIME_BITS'(cfg.debounce_ms);
    want             = ~level;

    pressed_next     = pressed;
    press_start_next = press_start;
    held_next        = held;
    press_edge       = 1'b0;
    release_edge     = 1'b0;

    if (stable) begin
      if (want && !pressed) begin
        pressed_next     = 1'b1;
        press_start_next = now;
        held_next        = 1'b0;
        press_edge       = 1'b1;
      end else if (!want && pressed) begin
        pressed_next = 1'b0;
        held_next    = 1'b0;
        release_edge = 1'b1;
      end else if (want && pressed) begin
        if ((now - press_start) > TIME_BITS'(cfg.hold_ms)) begin
          held_next = 1'b1;
        end
      end
    end

    recent = press_edge ||
             (pressed_next && ((now - press_start_next) < TIME_BITS'(cfg.edge_window_ms)));

    status.pressed      = pressed_next;
    status.press_edge   = press_edge;
    status.release_edge = release_edge;
    status.held         = held_next;
    status.recent       = recent;
    if (recent) begin
      status.ev = bdh_pkg::EV_PRESSED;
    end else if (release_edge) begin
      status.ev = bdh_pkg::EV_RELEASED;
    end else if (held_next) begin
      status.ev = bdh_pkg::EV_HELD;
    end else begin
      status.ev = bdh_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw    <= 1'b1;
      change_time <= '0;
      pressed     <= 1'b0;
      press_start <= '0;
      held        <= 1'b0;
    end else if (upd) begin
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
      pressed     <= pressed_next;
      press_start <= press_start_next;
      held        <= held_next;
    end
  end

endmodule

// ----- hdl/button_debounce_hold_detector_core.sv -----
`timescale 1ns / 1ps

// Debouncer with long-press detection for active-low push buttons.
//
// Input stream (s_*): one beat per sample, a millisecond timestamp plus the
// raw pin levels (0 = pressed). Output stream (m_*): one beat per sample with
// the debounced pressed, edge, held and recent-press masks, an any-pressed
// flag and a 2-bit event code per button (pressed, released, held, none).
// Configuration (cfg_*): index 0 debounce time, 1 hold time, 2 recent-press
// window, all in ms; cfg_ready is always high. Write only while idle.
//
// Path: a sample accepted into the input register moves into the result
// register, presented on m_*, as soon as the result register is free.
// Throughput: one sample per cycle while m_tready allows; the whole per-button
// update (subtract and compare against the thresholds) sits between the input
// and result registers, and the button state is updated in the same cycle.
// Stall: the result register holds while m_tready is low; the input register
// takes one more beat, then s_tready drops until the result is taken.
// Reset: synchronous, clears both stage valids, the button state (all
// released) and loads the default thresholds 50 / 1000 / 200 ms.
module button_debounce_hold_detector_core #(
  parameter int NUM_BUTTONS = bdh_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bdh_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata, from bit 0: now_ms[31:0], raw_levels[3:0], zero pad to 40 bits
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // m_tdata, from bit 0: pressed_mask[3:0], press_edge_mask[3:0],
  // release_edge_mask[3:0], held_mask[3:0], recent_press_mask[3:0],
  // any_pressed, event_up[1:0], event_down[1:0], event_select[1:0],
  // event_back[1:0], zero pad to 32 bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdh_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NOUT = bdh_pkg::OUT_BUTTONS;

  // Configuration registers
  bdh_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= bdh_pkg::DEBOUNCE_RST;
      cfg.hold_ms        <= bdh_pkg::HOLD_RST;
      cfg.edge_window_ms <= bdh_pkg::EDGE_WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdh_pkg::REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_data;
        bdh_pkg::REG_HOLD:        cfg.hold_ms        <= cfg_data;
        bdh_pkg::REG_EDGE_WINDOW: cfg.edge_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                      in_valid;
  logic [TIME_BITS-1:0]      in_now;
  logic [bdh_pkg::RAW_W-1:0] in_raw;
  logic                      adv;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now <= TIME_BITS'(s_tdata[bdh_pkg::NOW_W-1:0]);
      in_raw <= s_tdata[bdh_pkg::NOW_W +: bdh_pkg::RAW_W];
    end
  end

  // Per-button logic; buttons beyond the raw field read as released
  bdh_pkg::btn_status_t status [NUM_BUTTONS];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic level;
    if (i < bdh_pkg::RAW_W) begin : g_pin
      assign level = in_raw[i];
    end else begin : g_nopin
      assign level = 1'b1;
    end

    bdh_button #(
      .TIME_BITS(TIME_BITS)
    ) u_btn (
      .clk    (clk),
      .rst    (rst),
      .upd    (adv),
      .now    (in_now),
      .level  (level),
      .cfg    (cfg),
      .status (status[i])
    );
  end

  // Gather the first four buttons; missing ones report zero
  logic   [NOUT-1:0] pmask;
  logic   [NOUT-1:0] emask;
  logic   [NOUT-1:0] rmask;
  logic   [NOUT-1:0] hmask;
  logic   [NOUT-1:0] rcmask;
  bdh_pkg::event_t   ev [NOUT];

  for (genvar j = 0; j < NOUT; j++) begin : g_out
    if (j < NUM_BUTTONS) begin : g_used
      assign pmask[j]  = status[j].pressed;
      assign emask[j]  = status[j].press_edge;
      assign rmask[j]  = status[j].release_edge;
      assign hmask[j]  = status[j].held;
      assign rcmask[j] = status[j].recent;
      assign ev[j]     = status[j].ev;
    end else begin : g_unused
      assign pmask[j]  = 1'b0;
      assign emask[j]  = 1'b0;
      assign rmask[j]  = 1'b0;
      assign hmask[j]  = 1'b0;
      assign rcmask[j] = 1'b0;
      assign ev[j]     = bdh_pkg::EV_NONE;
    end
  end

  logic [31:0] result_next;

  assign result_next = {3'b000, ev[3], ev[2], ev[1], ev[0], |pmask,
                        rcmask, hmask, rmask, emask, pmask};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= result_next;
    end
  end

endmodule

// ----- tb/button_debounce_hold_detector_core_tb.sv -----
`timescale 1ns / 1ps

module button_debounce_hold_detector_core_tb;

  localparam int BUTTONS      = bdh_pkg::OUT_BUTTONS;
  localparam int DRAIN_CYCLES = 6;   // margin after the last result has come out
  localparam int FIELDS       = 11;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [39:0]                   s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [31:0]                   m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bdh_pkg::CFG_IDX_W-1:0] cfg_index = bdh_pkg::REG_DEBOUNCE;
  logic [bdh_pkg::CFG_W-1:0]     cfg_data  = '0;

  always #2 clk = ~clk;

  button_debounce_hold_detector_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: thresholds plus per-button debounce state
  // ---------------------------------------------------------------------------
  bdh_pkg::cfg_t             thr;
  logic [BUTTONS-1:0]        raw_seen;      // last raw level, 1 = released
  logic [BUTTONS-1:0]        deb_pressed;
  logic [BUTTONS-1:0]        held;
  logic [bdh_pkg::NOW_W-1:0] change_at [BUTTONS];
  logic [bdh_pkg::NOW_W-1:0] press_at  [BUTTONS];

  logic [31:0] status_due [$];        // predicted status words, oldest first
  int unsigned mismatches;
  int unsigned idle_pct;             // sender idle chance, percent
  int unsigned stall_pct;            // receiver stall chance, percent
  int unsigned beats_sent;

  // Status word layout, lowest bit up; last entry is the zero pad
  int    field_lo   [FIELDS] = '{0, 4, 8, 12, 16, 20, 21, 23, 25, 27, 29};
  int    field_w    [FIELDS] = '{4, 4, 4, 4, 4, 1, 2, 2, 2, 2, 3};
  string field_name [FIELDS] = '{"pressed_mask", "press_edge_mask", "release_edge_mask",
                                 "held_mask", "recent_press_mask", "any_pressed",
                                 "event_up", "event_down", "event_select", "event_back",
                                 "pad"};

  task automatic reset_predictor;
    thr.debounce_ms    = bdh_pkg::DEBOUNCE_RST;
    thr.hold_ms        = bdh_pkg::HOLD_RST;
    thr.edge_window_ms = bdh_pkg::EDGE_WINDOW_RST;
    raw_seen    = '1;
    deb_pressed = '0;
    held        = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      change_at[i] = '0;
      press_at[i]  = '0;
    end
  endtask

  // One sample through the debouncer; returns the status word it should produce.
  // All time differences are 32-bit and wrap.
  function automatic logic [31:0] debounce_update(input logic [bdh_pkg::NOW_W-1:0] now,
                                                  input logic [bdh_pkg::RAW_W-1:0] raw);
    logic [bdh_pkg::NOW_W-1:0] since_change;
    logic [BUTTONS-1:0]        p_edge;
    logic [BUTTONS-1:0]        r_edge;
    logic [BUTTONS-1:0]        recent;
    bdh_pkg::event_t           ev [BUTTONS];
    logic [31:0]               word;
    p_edge = '0;
    r_edge = '0;
    recent = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      // a level change restarts the stable timer, so this sample cannot pass
      if (raw[i] != raw_seen[i]) begin
        change_at[i] = now;
        raw_seen[i]  = raw[i];
      end
      since_change = now - change_at[i];
      if (since_change > bdh_pkg::NOW_W'(thr.debounce_ms)) begin
        if (!raw[i] && !deb_pressed[i]) begin
          deb_pressed[i] = 1'b1;
          press_at[i]    = now;
          held[i]        = 1'b0;
          p_edge[i]      = 1'b1;
        end else if (raw[i] && deb_pressed[i]) begin
          deb_pressed[i] = 1'b0;
          held[i]        = 1'b0;
          r_edge[i]      = 1'b1;
        end else if (!raw[i] && deb_pressed[i] && !held[i]) begin
          if (bdh_pkg::NOW_W'(now - press_at[i]) > bdh_pkg::NOW_W'(thr.hold_ms)) begin
            held[i] = 1'b1;
          end
        end
      end
      recent[i] = p_edge[i] ||
                  (deb_pressed[i] && bdh_pkg::NOW_W'(now - press_at[i]) <
                                     bdh_pkg::NOW_W'(thr.edge_window_ms));
      // pressed beats released beats held
      if (recent[i])      ev[i] = bdh_pkg::EV_PRESSED;
      else if (r_edge[i]) ev[i] = bdh_pkg::EV_RELEASED;
      else if (held[i])   ev[i] = bdh_pkg::EV_HELD;
      else                ev[i] = bdh_pkg::EV_NONE;
    end
    word        = '0;
    word[3:0]   = deb_pressed;
    word[7:4]   = p_edge;
    word[11:8]  = r_edge;
    word[15:12] = held;
    word[19:16] = recent;
    word[20]    = |deb_pressed;
    word[22:21] = ev[0];
    word[24:23] = ev[1];
    word[26:25] = ev[2];
    word[28:27] = ev[3];
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends just after a falling edge, so each
  // drive lands in a step of its own.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [bdh_pkg::NOW_W-1:0] now,
                             input logic [bdh_pkg::RAW_W-1:0] raw);
    // idle in bursts of the 50-beat cycle only, leaving runs of back-to-back beats
    if (idle_pct != 0 && (beats_sent % 50) >= 10) begin
      while ($urandom_range(99) < idle_pct) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, raw, now};
    do @(posedge clk); while (!s_tready);
    status_due.push_back(debounce_update(now, raw));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bdh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdh_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bdh_pkg::REG_DEBOUNCE:    thr.debounce_ms    = val;
      bdh_pkg::REG_HOLD:        thr.hold_ms        = val;
      bdh_pkg::REG_EDGE_WINDOW: thr.edge_window_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [bdh_pkg::CFG_W-1:0] deb,
                                input logic [bdh_pkg::CFG_W-1:0] hold,
                                input logic [bdh_pkg::CFG_W-1:0] window);
    write_reg(bdh_pkg::REG_DEBOUNCE, deb);
    write_reg(bdh_pkg::REG_HOLD, hold);
    write_reg(bdh_pkg::REG_EDGE_WINDOW, window);
  endtask

  // Hold the sender back until every predicted beat has come out, then let the
  // pipeline settle; thresholds may be rewritten after this.
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure, beats checked at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_beat
    logic [31:0] want;
    logic [31:0] exp_f;
    logic [31:0] got_f;
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want = status_due.pop_front();
        for (int f = 0; f < FIELDS; f++) begin
          exp_f = (want    >> field_lo[f]) & ((32'd1 << field_w[f]) - 1);
          got_f = (m_tdata >> field_lo[f]) & ((32'd1 << field_w[f]) - 1);
          if (exp_f != got_f) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, field_name[f], exp_f, got_f);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset thresholds 50 / 1000 / 200: debounce boundary, recent window
  // boundary, hold boundary, release. All four buttons move together.
  task automatic test_default_thresholds;
    send_sample(32'd0,    4'hF);   // nothing changed, nothing stable yet
    send_sample(32'd100,  4'hF);   // stable released, no edge
    send_sample(32'd110,  4'h0);   // all pressed: change, timer restarts
    send_sample(32'd160,  4'h0);   // exactly 50 ms: not yet accepted
    send_sample(32'd161,  4'h0);   // press edge on all
    send_sample(32'd300,  4'h0);   // still recent
    send_sample(32'd361,  4'h0);   // age 200: no longer recent
    send_sample(32'd1161, 4'h0);   // age 1000: not held yet
    send_sample(32'd1162, 4'h0);   // held
    send_sample(32'd1170, 4'hF);   // release bouncing in, still held
    send_sample(32'd1221, 4'hF);   // release edge
    drain_results();
  endtask

  // Timestamp wrap and time running backwards
  task automatic test_time_wrap;
    send_sample(32'hFFFF_FF00, 4'hE);  // button 0 goes down just before the wrap
    send_sample(32'hFFFF_FFFF, 4'hE);  // accepted at all-ones time
    send_sample(32'h0000_0040, 4'hE);  // across the wrap, press age 65
    send_sample(32'h0000_0010, 4'hC);  // time steps back, button 1 goes down
    send_sample(32'h0000_0005, 4'hC);  // backwards again: huge difference, accepted
    send_sample(32'h8000_0000, 4'hC);  // both held
    drain_results();
  endtask

  // Zero thresholds: one ms of stability is enough, window only shows the edge
  task automatic test_zero_thresholds;
    set_thresholds(16'd0, 16'd0, 16'd0);
    send_sample(32'd10000, 4'hF);
    send_sample(32'd10001, 4'hF);      // everything released
    send_sample(32'd10001, 4'h7);      // button 3 down
    send_sample(32'd10001, 4'h7);      // zero difference is not greater than zero
    send_sample(32'd10002, 4'h7);      // press edge, recent through the edge alone
    send_sample(32'd10003, 4'h7);      // held at once, not recent
    drain_results();
  endtask

  // Full-scale thresholds
  task automatic test_max_thresholds;
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(32'd20000,  4'hB);     // button 2 down, others released
    send_sample(32'd85535,  4'hB);     // exactly 65535: not accepted
    send_sample(32'd85536,  4'hB);     // press edge
    send_sample(32'd151070, 4'hB);     // age 65534: recent
    send_sample(32'd151071, 4'hB);     // age 65535: neither recent nor held
    send_sample(32'd151072, 4'hB);     // held
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random phase: mostly clean press/release sequences with short bounce bursts,
  // time moving forward in steps scaled to the thresholds; some jumps, some
  // backward steps and some fully random pin samples.
  // ---------------------------------------------------------------------------
  function automatic logic [bdh_pkg::CFG_W-1:0] pick_threshold;
    case ($urandom_range(3))
      0:       return bdh_pkg::CFG_W'($urandom_range(8));
      1:       return bdh_pkg::CFG_W'($urandom_range(10, 300));
      2:       return bdh_pkg::CFG_W'($urandom_range(300, 3000));
      default: return bdh_pkg::CFG_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_random(input int unsigned n_items, input int unsigned send_idle,
                             input int unsigned recv_stall);
    logic [bdh_pkg::NOW_W-1:0] now;
    logic [bdh_pkg::RAW_W-1:0] steady;
    logic [bdh_pkg::RAW_W-1:0] raw;
    int unsigned               bounce [BUTTONS];
    int unsigned               span;
    int unsigned               step;
    int unsigned               r;
    set_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
    span = 32'(thr.debounce_ms);
    if (32'(thr.hold_ms) > span)        span = 32'(thr.hold_ms);
    if (32'(thr.edge_window_ms) > span) span = 32'(thr.edge_window_ms);
    step   = 1 + span / 16;
    now    = $urandom;
    steady = bdh_pkg::RAW_W'($urandom);
    raw    = steady;
    for (int i = 0; i < BUTTONS; i++) bounce[i] = 0;
    beats_sent = 0;
    idle_pct   = send_idle;
    stall_pct  = recv_stall;
    for (int k = 0; k < n_items; k++) begin
      // halfway through, the sender waits for every outstanding result
      if (k == n_items / 2) drain_results();
      r = $urandom_range(99);
      if (r < 2)      now = $urandom;
      else if (r < 5) now = now - $urandom_range(1, 4 * step);
      else            now = now + $urandom_range(0, 2 * step);
      if ($urandom_range(99) < 3) begin
        raw = bdh_pkg::RAW_W'($urandom);
      end else begin
        for (int i = 0; i < BUTTONS; i++) begin
          if (bounce[i] != 0) begin
            bounce[i]--;
            raw[i] = (bounce[i] == 0) ? steady[i] : 1'($urandom_range(1));
          end else if ($urandom_range(99) < 3) begin
            steady[i] = ~steady[i];
            bounce[i] = $urandom_range(4);
            raw[i]    = (bounce[i] == 0) ? steady[i] : ~steady[i];
          end else begin
            raw[i] = steady[i];
          end
        end
      end
      send_sample(now, raw);
    end
    drain_results();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_thresholds();
    test_time_wrap();
    test_zero_thresholds();
    test_max_thresholds();
    test_random(262, 0, 0);
    test_random(262, 81, 0);
    test_random(262, 0, 81);
    test_random(262, 26, 26);

    if (mismatches == 0 && status_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bdh_pkg.sv
hdl/bdh_button.sv
hdl/button_debounce_hold_detector_core.sv
tb/button_debounce_hold_detector_core_tb.sv
